// ===== sv/multi_channel_echo_ranger_top_defines.svh =====
// ----------------------------------------------------------------------------
// multi-channel echo ranger assertion macros
// shared property forms for the ranger checks
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_ECHO_RANGER_TOP_DEFINES_SVH
`define MULTI_CHANNEL_ECHO_RANGER_TOP_DEFINES_SVH

// implication checked outside reset
`define MCER_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ranger check failed");

// next-cycle implication, also checked across reset
`define MCER_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ranger check failed");

`endif

// ===== sv/mcer_pkg.sv =====
// ----------------------------------------------------------------------------
// mcer_pkg
// types and constants of the multi-channel echo ranger
// ----------------------------------------------------------------------------
package mcer_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_LISTEN
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_FIX,
    S_CHECK,
    S_STATUS,
    S_REPORT
  } state_t;

  localparam int unsigned TRIG_LOW_TICKS  = 5;
  localparam int unsigned TRIG_HIGH_TICKS = 10;
  localparam int unsigned TRIG_TICKS      = TRIG_LOW_TICKS + TRIG_HIGH_TICKS;

  localparam logic [19:0] TIMEOUT_RESET = 20'd30000;

  // distance_cm = us * 17 / 1000, division by a truncated reciprocal
  localparam logic [4:0]  CM_NUM      = 5'd17;
  localparam logic [9:0]  CM_DEN      = 10'd1000;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [20:0] RECIP_MUL   = 21'((64'd1 << RECIP_SHIFT) / 64'd1000);

endpackage

// ===== sv/multi_channel_echo_ranger_top.sv =====
// ----------------------------------------------------------------------------
// multi_channel_echo_ranger_top
// pulse-width echo ranger for several ultrasonic channels
//
// input channel (in_valid/in_stall): kind 0 starts a measurement, kind 1 is
// one microsecond tick carrying echo_levels, bit i for channel i.
// output channel (out_valid/out_stall): status and report items.
// every input item yields one status item, except the listen tick that
// closes a measurement, which yields CHANNELS report items, last on the final.
// timeout_us is to be written through cfg_wr_en/cfg_wr_data while idle; the
// block does not enforce it. start, idle and trigger ticks pass through the
// status state to the output register. a listen tick walks the channels one
// per cycle, and every channel whose echo falls adds the mul and fix steps on
// the shared reciprocal multiplier, then check and status follow. when the
// measurement closes, status gives way to mul and fix for the timeout
// distance, then to reporting. in_stall is high for the whole walk.
// reset returns to idle with timeout_us at 30000 and the output register empty.
// while out_stall is high the held item stays and the sequencer waits.
// ----------------------------------------------------------------------------
`include "multi_channel_echo_ranger_top_defines.svh"

module multi_channel_echo_ranger_top #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  echo_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        trigger_level,
  output logic        busy_res,
  output logic        report_valid,
  output logic [2:0]  channel,
  output logic [14:0] distance_cm,
  output logic        timed_out,
  output logic        last
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  mcer_pkg::state_t state, state_next;
  mcer_pkg::phase_t phase;

  logic [19:0]         timeout_us;
  logic [19:0]         tick_count;
  logic [CHANNELS-1:0] seen;
  logic [CHANNELS-1:0] fin;
  logic [19:0]         rise_time [CHANNELS];
  logic [14:0]         chan_dist [CHANNELS];
  logic [3:0]          fin_count;
  logic [CH_W-1:0]     ch;
  logic [7:0]          lv;
  logic [19:0]         opnd;
  logic                dflt_mode;
  logic [24:0]         prod_x;
  logic [45:0]         prod;
  logic [14:0]         dflt_dist;
  logic                stat_trig;
  logic                stat_busy;

  logic        out_free;
  logic        out_load;
  logic        high;
  logic        rise_now;
  logic        fin_now;
  logic [19:0] tick_inc;
  logic        done_now;
  logic [24:0] x;
  logic [14:0] q;
  logic [24:0] qk;
  logic [24:0] r;
  logic [14:0] dist_q;

  assign in_stall = (state != mcer_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && (state == mcer_pkg::S_STATUS || state == mcer_pkg::S_REPORT);
  assign high     = lv[3'(ch)];
  assign rise_now = !seen[ch] && high;
  assign fin_now  = seen[ch] && !fin[ch] && !high;
  assign tick_inc = tick_count + 20'd1;
  assign done_now = (fin_count >= 4'(CHANNELS)) || (tick_inc >= timeout_us);

  // shared ranging unit: x = us * 17, then q = x / 1000 with one correction
  assign x      = 25'(opnd) * 25'(mcer_pkg::CM_NUM);
  assign q      = prod[mcer_pkg::RECIP_SHIFT +: 15];
  assign qk     = 25'(q) * 25'(mcer_pkg::CM_DEN);
  assign r      = prod_x - qk;
  assign dist_q = (r >= 25'(mcer_pkg::CM_DEN)) ? q + 15'd1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcer_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mcer_pkg::S_IDLE: begin
        if (in_valid) begin
          if (kind && phase == mcer_pkg::PH_LISTEN) begin
            state_next = mcer_pkg::S_SCAN;
          end else begin
            state_next = mcer_pkg::S_STATUS;
          end
        end
      end
      mcer_pkg::S_SCAN: begin
        if (fin_now) begin
          state_next = mcer_pkg::S_MUL;
        end else if (ch == CH_LAST) begin
          state_next = mcer_pkg::S_CHECK;
        end
      end
      mcer_pkg::S_MUL: begin
        state_next = mcer_pkg::S_FIX;
      end
      mcer_pkg::S_FIX: begin
        if (dflt_mode) begin
          state_next = mcer_pkg::S_REPORT;
        end else if (ch == CH_LAST) begin
          state_next = mcer_pkg::S_CHECK;
        end else begin
          state_next = mcer_pkg::S_SCAN;
        end
      end
      mcer_pkg::S_CHECK: begin
        state_next = done_now ? mcer_pkg::S_MUL : mcer_pkg::S_STATUS;
      end
      mcer_pkg::S_STATUS: begin
        if (out_free) begin
          state_next = mcer_pkg::S_IDLE;
        end
      end
      mcer_pkg::S_REPORT: begin
        if (out_free && ch == CH_LAST) begin
          state_next = mcer_pkg::S_IDLE;
        end
      end
      default: state_next = mcer_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= mcer_pkg::PH_IDLE;
      tick_count <= '0;
      seen       <= '0;
      fin        <= '0;
      fin_count  <= '0;
      timeout_us <= mcer_pkg::TIMEOUT_RESET;
      dflt_mode  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_us <= cfg_wr_data;
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        mcer_pkg::S_IDLE: begin
          if (in_valid) begin
            lv        <= echo_levels;
            ch        <= '0;
            dflt_mode <= 1'b0;
            if (!kind) begin
              stat_busy <= 1'b1;
              if (phase == mcer_pkg::PH_IDLE) begin
                stat_trig  <= 1'b0;
                phase      <= mcer_pkg::PH_TRIG;
                tick_count <= '0;
                seen       <= '0;
                fin        <= '0;
                fin_count  <= '0;
              end else begin
                stat_trig <= (phase == mcer_pkg::PH_TRIG) &&
                             (tick_count > 20'(mcer_pkg::TRIG_LOW_TICKS));
              end
            end else if (phase == mcer_pkg::PH_IDLE) begin
              stat_busy <= 1'b0;
              stat_trig <= 1'b0;
            end else if (phase == mcer_pkg::PH_TRIG) begin
              stat_busy <= 1'b1;
              stat_trig <= (tick_count >= 20'(mcer_pkg::TRIG_LOW_TICKS));
              if (tick_inc >= 20'(mcer_pkg::TRIG_TICKS)) begin
                phase      <= mcer_pkg::PH_LISTEN;
                tick_count <= '0;
              end else begin
                tick_count <= tick_inc;
              end
            end
          end
        end
        mcer_pkg::S_SCAN: begin
          if (rise_now) begin
            rise_time[ch] <= tick_count;
            seen[ch]      <= 1'b1;
          end
          if (fin_now) begin
            opnd <= tick_count - rise_time[ch];
          end else if (ch != CH_LAST) begin
            ch <= ch + CH_W'(1);
          end
        end
        mcer_pkg::S_MUL: begin
          prod_x <= x;
          prod   <= 46'(x) * 46'(mcer_pkg::RECIP_MUL);
        end
        mcer_pkg::S_FIX: begin
          if (dflt_mode) begin
            dflt_dist <= dist_q;
            ch        <= '0;
          end else begin
            chan_dist[ch] <= dist_q;
            fin[ch]       <= 1'b1;
            fin_count     <= fin_count + 4'd1;
            if (ch != CH_LAST) begin
              ch <= ch + CH_W'(1);
            end
          end
        end
        mcer_pkg::S_CHECK: begin
          if (done_now) begin
            phase      <= mcer_pkg::PH_IDLE;
            tick_count <= '0;
            opnd       <= timeout_us;
            dflt_mode  <= 1'b1;
          end else begin
            tick_count <= tick_inc;
            stat_trig  <= 1'b0;
            stat_busy  <= 1'b1;
          end
        end
        mcer_pkg::S_STATUS: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            trigger_level <= stat_trig;
            busy_res      <= stat_busy;
            report_valid  <= 1'b0;
            channel       <= '0;
            distance_cm   <= '0;
            timed_out     <= 1'b0;
            last          <= 1'b1;
          end
        end
        mcer_pkg::S_REPORT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            trigger_level <= 1'b0;
            busy_res      <= 1'b0;
            report_valid  <= 1'b1;
            channel       <= 3'(ch);
            distance_cm   <= fin[ch] ? chan_dist[ch] : dflt_dist;
            timed_out     <= !fin[ch];
            last          <= (ch == CH_LAST);
            if (ch != CH_LAST) begin
              ch <= ch + CH_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // report items close a measurement
  `MCER_ASSERT_IMP(a_report_not_busy, clk, rst, out_valid && report_valid, !busy_res && !trigger_level)
  // timed-out flag only rides on reports
  `MCER_ASSERT_IMP(a_timeout_on_report, clk, rst, out_valid && timed_out, report_valid)
  // finished channels never exceed the channel count
  `MCER_ASSERT_IMP(a_fin_count_range, clk, rst, 1'b1, fin_count <= 4'(CHANNELS))
  // reset leaves idle with nothing on the output
  `MCER_ASSERT_NEXT(a_reset_idle, clk, rst, phase == mcer_pkg::PH_IDLE && !out_valid)

endmodule
